FILE: sv/cps_pkg.sv
// Package for the closest-point-on-segment block: field widths, region codes,
// request, response and pipeline control types. No dependencies.
package cps_pkg;

    localparam int FIELD_W         = 32;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC_BITS_DEF = 16;

    localparam logic [1:0] REGION_START      = 2'd0;
    localparam logic [1:0] REGION_INTERIOR   = 2'd1;
    localparam logic [1:0] REGION_END        = 2'd2;
    localparam logic [1:0] REGION_DEGENERATE = 2'd3;

    typedef struct packed {
        logic signed [FIELD_W-1:0] start_x;
        logic signed [FIELD_W-1:0] start_y;
        logic signed [FIELD_W-1:0] end_x;
        logic signed [FIELD_W-1:0] end_y;
        logic signed [FIELD_W-1:0] query_x;
        logic signed [FIELD_W-1:0] query_y;
    } cps_req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] closest_x;
        logic signed [FIELD_W-1:0] closest_y;
        logic [1:0]                region;
    } cps_rsp_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] region;
    } cps_ctrl_t;

endpackage

FILE: sv/cps_front.sv
// Front end: coordinate differences, the four products and the sums num and den.
// Three register stages. Depends on cps_pkg.
module cps_front import cps_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  cps_req_t                  request,
    output cps_ctrl_t                 ctrl,
    output logic signed [2*COORD_WIDTH+2:0] num,
    output logic [2*COORD_WIDTH+1:0]  den,
    output logic [6*COORD_WIDTH+1:0]  ctx
);
    localparam int CW    = COORD_WIDTH;
    localparam int DL    = CW + 1;
    localparam int PW    = 2 * CW + 2;
    localparam int NW    = 2 * CW + 3;
    localparam int DW    = 2 * CW + 2;
    localparam int CTX_W = 6 * CW + 2;

    logic signed [CW-1:0] sx, sy, ex, ey, qx, qy;
    logic signed [DL-1:0] dx_next, dy_next, vx_next, vy_next;
    logic signed [DL-1:0] dx1, dy1, vx_reg, vy_reg;
    logic [CTX_W-1:0]     ctx1_next, ctx1_reg, ctx2_reg, ctx3_reg;
    logic signed [PW-1:0] pxv_next, pyv_next, pxx_next, pyy_next;
    logic signed [PW-1:0] pxv_reg, pyv_reg, pxx_reg, pyy_reg;
    logic signed [NW-1:0] num_next, num_reg, den_sum;
    logic [DW-1:0]        den_next, den_reg;
    logic                 v1_reg, v2_reg, v3_reg;

    always_comb
    begin
        sx = request.start_x[CW-1:0];
        sy = request.start_y[CW-1:0];
        ex = request.end_x[CW-1:0];
        ey = request.end_y[CW-1:0];
        qx = request.query_x[CW-1:0];
        qy = request.query_y[CW-1:0];
        dx_next = DL'(ex) - DL'(sx);
        dy_next = DL'(ey) - DL'(sy);
        vx_next = DL'(qx) - DL'(sx);
        vy_next = DL'(qy) - DL'(sy);
        ctx1_next = {sx, sy, ex, ey, dx_next, dy_next};
    end

    assign dy1 = ctx1_reg[DL-1:0];
    assign dx1 = ctx1_reg[2*DL-1:DL];

    always_comb
    begin
        pxv_next = PW'(dx1) * PW'(vx_reg);
        pyv_next = PW'(dy1) * PW'(vy_reg);
        pxx_next = PW'(dx1) * PW'(dx1);
        pyy_next = PW'(dy1) * PW'(dy1);
    end

    always_comb
    begin
        num_next = NW'(pxv_reg) + NW'(pyv_reg);
        den_sum  = NW'(pxx_reg) + NW'(pyy_reg);
        den_next = den_sum[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx1_reg <= ctx1_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        pxv_reg  <= pxv_next;
        pyv_reg  <= pyv_next;
        pxx_reg  <= pxx_next;
        pyy_reg  <= pyy_next;
        ctx2_reg <= ctx1_reg;
        num_reg  <= num_next;
        den_reg  <= den_next;
        ctx3_reg <= ctx2_reg;
    end

    assign ctrl.valid  = v3_reg;
    assign ctrl.region = REGION_START;
    assign num = num_reg;
    assign den = den_reg;
    assign ctx = ctx3_reg;

endmodule

FILE: sv/cps_div_step.sv
// One restoring division step: shifts the remainder, subtracts the divisor when
// it fits and appends one quotient bit. Depends on cps_pkg.
module cps_div_step import cps_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cps_ctrl_t                 ctrl_in,
    input  logic [2*COORD_WIDTH+1:0]  rem_in,
    input  logic [2*COORD_WIDTH+1:0]  den_in,
    input  logic [T_FRAC_BITS:0]      t_in,
    input  logic [6*COORD_WIDTH+1:0]  ctx_in,
    output cps_ctrl_t                 ctrl_out,
    output logic [2*COORD_WIDTH+1:0]  rem_out,
    output logic [2*COORD_WIDTH+1:0]  den_out,
    output logic [T_FRAC_BITS:0]      t_out,
    output logic [6*COORD_WIDTH+1:0]  ctx_out
);
    localparam int DW    = 2 * COORD_WIDTH + 2;
    localparam int TW    = T_FRAC_BITS + 1;
    localparam int CTX_W = 6 * COORD_WIDTH + 2;

    logic [DW:0]       shifted, diff;
    logic              fits;
    logic [DW-1:0]     rem_next, rem_reg, den_reg;
    logic [TW-1:0]     t_next, t_reg;
    logic [CTX_W-1:0]  ctx_reg;
    cps_ctrl_t         ctrl_reg;

    always_comb
    begin
        shifted  = {rem_in, 1'b0};
        diff     = shifted - {1'b0, den_in};
        fits     = shifted >= {1'b0, den_in};
        rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
        t_next   = {t_in[TW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        t_reg   <= t_next;
        ctx_reg <= ctx_in;
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign t_out    = t_reg;
    assign ctx_out  = ctx_reg;

endmodule

FILE: sv/cps_divider.sv
// Region classification followed by a pipelined restoring divider that forms
// the projection fraction t. Depends on cps_pkg and cps_div_step.
module cps_divider import cps_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cps_ctrl_t                 ctrl_in,
    input  logic signed [2*COORD_WIDTH+2:0] num,
    input  logic [2*COORD_WIDTH+1:0]  den,
    input  logic [6*COORD_WIDTH+1:0]  ctx_in,
    output cps_ctrl_t                 ctrl_out,
    output logic [T_FRAC_BITS:0]      t,
    output logic [6*COORD_WIDTH+1:0]  ctx_out
);
    localparam int NW    = 2 * COORD_WIDTH + 3;
    localparam int DW    = 2 * COORD_WIDTH + 2;
    localparam int TW    = T_FRAC_BITS + 1;
    localparam int CTX_W = 6 * COORD_WIDTH + 2;

    logic              equal;
    cps_ctrl_t         ctrl_next, ctrl_reg;
    logic [DW-1:0]     rem_next, rem_reg, den_reg;
    logic [TW-1:0]     t_next, t_reg;
    logic [CTX_W-1:0]  ctx_reg;

    cps_ctrl_t         ctrl_s [T_FRAC_BITS+1];
    logic [DW-1:0]     rem_s  [T_FRAC_BITS+1];
    logic [DW-1:0]     den_s  [T_FRAC_BITS+1];
    logic [TW-1:0]     t_s    [T_FRAC_BITS+1];
    logic [CTX_W-1:0]  ctx_s  [T_FRAC_BITS+1];

    // The first quotient bit is the integer part, set only when num equals den.
    always_comb
    begin
        ctrl_next.valid = ctrl_in.valid;
        if (den == '0)
        begin
            ctrl_next.region = REGION_DEGENERATE;
        end
        else if (num[NW-1])
        begin
            ctrl_next.region = REGION_START;
        end
        else if (num > $signed({1'b0, den}))
        begin
            ctrl_next.region = REGION_END;
        end
        else
        begin
            ctrl_next.region = REGION_INTERIOR;
        end
        equal    = (num[DW-1:0] == den);
        rem_next = equal ? '0 : num[DW-1:0];
        t_next   = TW'(equal);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den;
        t_reg   <= t_next;
        ctx_reg <= ctx_in;
    end

    assign ctrl_s[0] = ctrl_reg;
    assign rem_s[0]  = rem_reg;
    assign den_s[0]  = den_reg;
    assign t_s[0]    = t_reg;
    assign ctx_s[0]  = ctx_reg;

    for (genvar k = 0; k < T_FRAC_BITS; k++)
    begin : g_step
        cps_div_step #(
            .COORD_WIDTH (COORD_WIDTH),
            .T_FRAC_BITS (T_FRAC_BITS)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_s[k]),
            .rem_in   (rem_s[k]),
            .den_in   (den_s[k]),
            .t_in     (t_s[k]),
            .ctx_in   (ctx_s[k]),
            .ctrl_out (ctrl_s[k+1]),
            .rem_out  (rem_s[k+1]),
            .den_out  (den_s[k+1]),
            .t_out    (t_s[k+1]),
            .ctx_out  (ctx_s[k+1])
        );
    end

    assign ctrl_out = ctrl_s[T_FRAC_BITS];
    assign t        = t_s[T_FRAC_BITS];
    assign ctx_out  = ctx_s[T_FRAC_BITS];

endmodule

FILE: sv/cps_interp.sv
// Interpolation along the segment and result selection: multiplies the deltas
// by t, adds the start point and registers the result. Depends on cps_pkg.
module cps_interp import cps_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cps_ctrl_t                 ctrl_in,
    input  logic [T_FRAC_BITS:0]      t,
    input  logic [6*COORD_WIDTH+1:0]  ctx_in,
    output logic                      done,
    output cps_rsp_t                  result
);
    localparam int CW    = COORD_WIDTH;
    localparam int DL    = CW + 1;
    localparam int PW    = CW + T_FRAC_BITS + 2;
    localparam int CTX_W = 6 * CW + 2;

    logic signed [DL-1:0] dx, dy;
    logic signed [PW-1:0] prod_x_next, prod_y_next, prod_x_reg, prod_y_reg;
    logic [CTX_W-1:0]     ctx_reg;
    cps_ctrl_t            ctrl_reg;
    logic signed [CW-1:0] sx, sy, ex, ey, ix, iy, px, py;
    cps_rsp_t             result_next, result_reg;
    logic                 done_reg;

    assign dy = ctx_in[DL-1:0];
    assign dx = ctx_in[2*DL-1:DL];

    always_comb
    begin
        prod_x_next = PW'(dx) * PW'({1'b0, t});
        prod_y_next = PW'(dy) * PW'({1'b0, t});
    end

    always_comb
    begin
        ey = ctx_reg[2*DL+CW-1:2*DL];
        ex = ctx_reg[2*DL+2*CW-1:2*DL+CW];
        sy = ctx_reg[2*DL+3*CW-1:2*DL+2*CW];
        sx = ctx_reg[2*DL+4*CW-1:2*DL+3*CW];
        ix = sx + prod_x_reg[T_FRAC_BITS+CW-1:T_FRAC_BITS];
        iy = sy + prod_y_reg[T_FRAC_BITS+CW-1:T_FRAC_BITS];
        case (ctrl_reg.region)
            REGION_INTERIOR:
            begin
                px = ix;
                py = iy;
            end
            REGION_END:
            begin
                px = ex;
                py = ey;
            end
            default:
            begin
                px = sx;
                py = sy;
            end
        endcase
        result_next.closest_x = FIELD_W'(px);
        result_next.closest_y = FIELD_W'(py);
        result_next.region    = ctrl_reg.region;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
            done_reg <= ctrl_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        ctx_reg    <= ctx_in;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: sv/closest_point_on_segment.sv
// Top level of the closest-point-on-segment block: front end, divider and
// interpolation pipeline. Depends on cps_pkg, cps_front, cps_divider, cps_interp.
//
// Usage: a request (segment start, segment end, query point, signed fixed point)
// is taken at every rising edge with start high and busy low. busy is always low:
// the block is a fully pipelined datapath and takes a new request every cycle.
// Each request gives exactly one result on result, marked by done for a single
// cycle, in request order. The receiver cannot hold results off and need not.
// The pipeline has three stages for differences, products and sums, one
// classification stage, one restoring division stage per fraction bit of t,
// one multiply stage and one output stage. Throughput is one request per cycle.
// region gives start clamp, interior, end clamp or degenerate segment; the
// degenerate case returns the start point.
// Reset clears every valid bit in the pipeline, so no result appears for a
// request that was in flight.
module closest_point_on_segment import cps_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  cps_req_t request,
    output logic     done,
    output cps_rsp_t result
);
    localparam int LATENCY = T_FRAC_BITS + 6;
    localparam int NW      = 2 * COORD_WIDTH + 3;
    localparam int DW      = 2 * COORD_WIDTH + 2;
    localparam int CTX_W   = 6 * COORD_WIDTH + 2;

    logic                 accept;
    cps_ctrl_t            front_ctrl, div_ctrl;
    logic signed [NW-1:0] num;
    logic [DW-1:0]        den;
    logic [CTX_W-1:0]     front_ctx, div_ctx;
    logic [T_FRAC_BITS:0] t;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cps_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (accept),
        .request  (request),
        .ctrl     (front_ctrl),
        .num      (num),
        .den      (den),
        .ctx      (front_ctx)
    );

    cps_divider #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (front_ctrl),
        .num      (num),
        .den      (den),
        .ctx_in   (front_ctx),
        .ctrl_out (div_ctrl),
        .t        (t),
        .ctx_out  (div_ctx)
    );

    cps_interp #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_interp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl_in (div_ctrl),
        .t       (t),
        .ctx_in  (div_ctx),
        .done    (done),
        .result  (result)
    );

    // Every accepted request yields a result once it has passed the whole pipeline.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result missing after pipeline latency");

    // A segment with equal endpoints is reported as degenerate.
    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.start_x == request.end_x && request.start_y == request.end_y)
        |-> ##LATENCY (result.region == REGION_DEGENERATE))
        else $error("degenerate segment not flagged");

    // A query on the start point of a proper segment projects to the interior.
    a_query_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.query_x == request.start_x
            && request.query_y == request.start_y
            && request.start_x[COORD_WIDTH-1:0] != request.end_x[COORD_WIDTH-1:0])
        |-> ##LATENCY (result.region == REGION_INTERIOR))
        else $error("query on start point not reported as interior");

endmodule

FILE: dv/closest_point_on_segment_tb.sv
// Self-checking testbench for closest_point_on_segment: directed corner requests, then
// random segment and query requests under varying sender gaps, checked against a predictor.
// Depends on cps_pkg and the closest_point_on_segment RTL.
module closest_point_on_segment_tb import cps_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int TF          = T_FRAC_BITS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int MINV        = 32'sh8000_0000;
    localparam int MAXV        = 32'sh7fff_ffff;
    localparam int ONE         = 65536;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     start;
    logic     busy;
    cps_req_t request;
    logic     done;
    cps_rsp_t result;

    cps_rsp_t pending_points[$];
    int       mismatch_count = 0;
    int       requests_taken = 0;
    int       region_seen[4] = '{0, 0, 0, 0};
    int       idle_pct       = 0;
    int       stall_cycles   = 0;

    closest_point_on_segment #(
        .COORD_WIDTH(CW),
        .T_FRAC_BITS(TF)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic signed [127:0] to_coord(logic [31:0] v);
        logic signed [127:0] r;
        r = {96'd0, v};
        r = r <<< (128 - CW);
        return r >>> (128 - CW);
    endfunction

    function automatic cps_rsp_t project_onto_segment(cps_req_t req);
        logic signed [127:0] sx, sy, ex, ey, qx, qy;
        logic signed [127:0] dx, dy, num, den, t, off_x, off_y;
        cps_rsp_t rsp;
        sx  = to_coord(req.start_x);
        sy  = to_coord(req.start_y);
        ex  = to_coord(req.end_x);
        ey  = to_coord(req.end_y);
        qx  = to_coord(req.query_x);
        qy  = to_coord(req.query_y);
        dx  = ex - sx;
        dy  = ey - sy;
        num = dx * (qx - sx) + dy * (qy - sy);
        den = dx * dx + dy * dy;
        if (den == 0)
        begin
            rsp.closest_x = sx[31:0];
            rsp.closest_y = sy[31:0];
            rsp.region    = REGION_DEGENERATE;
        end
        else if (num < 0)
        begin
            rsp.closest_x = sx[31:0];
            rsp.closest_y = sy[31:0];
            rsp.region    = REGION_START;
        end
        else if (num > den)
        begin
            rsp.closest_x = ex[31:0];
            rsp.closest_y = ey[31:0];
            rsp.region    = REGION_END;
        end
        else
        begin
            t     = (num <<< TF) / den;
            off_x = (dx * t) >>> TF;
            off_y = (dy * t) >>> TF;
            rsp.closest_x = sx[31:0] + off_x[31:0];
            rsp.closest_y = sy[31:0] + off_y[31:0];
            rsp.region    = REGION_INTERIOR;
        end
        return rsp;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        cps_rsp_t want;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                pending_points.push_back(project_onto_segment(request));
                requests_taken++;
            end
            if (done)
            begin
                if (pending_points.size() == 0)
                    report_mismatch($sformatf("result %h with no request outstanding", result));
                else
                begin
                    want = pending_points.pop_front();
                    region_seen[want.region]++;
                    if (result.closest_x !== want.closest_x)
                        report_mismatch($sformatf("closest_x %h, expected %h",
                                                  result.closest_x, want.closest_x));
                    if (result.closest_y !== want.closest_y)
                        report_mismatch($sformatf("closest_y %h, expected %h",
                                                  result.closest_y, want.closest_y));
                    if (result.region !== want.region)
                        report_mismatch($sformatf("region %0d, expected %0d",
                                                  result.region, want.region));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no request or result for %0d cycles.", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic send_request(input cps_req_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic cps_req_t make_req(int sx, int sy, int ex, int ey, int qx, int qy);
        cps_req_t r;
        r.start_x = sx;
        r.start_y = sy;
        r.end_x   = ex;
        r.end_y   = ey;
        r.query_x = qx;
        r.query_y = qy;
        return r;
    endfunction

    function automatic logic [31:0] jitter_around(logic [31:0] c, int k);
        return c + (($urandom & ((32'd2 << k) - 32'd1)) - (32'd1 << k));
    endfunction

    function automatic logic [31:0] along(logic [31:0] s, logic [31:0] e, int frac);
        longint step;
        step = (longint'($signed(e - s)) * frac) >>> 8;
        return s + step[31:0];
    endfunction

    function automatic cps_req_t random_request();
        cps_req_t    r;
        logic [31:0] cx, cy;
        int          mode, k, frac;
        mode = $urandom_range(99);
        k    = $urandom_range(30);
        cx   = $urandom;
        cy   = $urandom;
        r.start_x = jitter_around(cx, k);
        r.start_y = jitter_around(cy, k);
        r.end_x   = jitter_around(cx, k);
        r.end_y   = jitter_around(cy, k);
        r.query_x = jitter_around(cx, k);
        r.query_y = jitter_around(cy, k);
        if (mode < 10)
            r = make_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else if (mode < 16)
        begin
            r.end_x = r.start_x;
            r.end_y = r.start_y;
        end
        else if (mode < 24)
        begin
            if ($urandom_range(1))
            begin
                r.query_x = r.start_x;
                r.query_y = r.start_y;
            end
            else
            begin
                r.query_x = r.end_x;
                r.query_y = r.end_y;
            end
        end
        else if (mode < 65)
        begin
            frac = int'($urandom_range(296)) - 20;
            k    = $urandom_range(k);
            r.query_x = jitter_around(along(r.start_x, r.end_x, frac), k);
            r.query_y = jitter_around(along(r.start_y, r.end_y, frac), k);
        end
        return r;
    endfunction

    task automatic test_directed_corners();
        idle_pct = 28;
        send_request(make_req(MINV, MINV, MINV, MINV, MINV, MINV));
        send_request(make_req(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
        send_request(make_req(MINV, MINV, MAXV, MAXV, MAXV, MINV));
        send_request(make_req(MINV, MINV, MAXV, MAXV, MINV, MINV));
        send_request(make_req(MINV, MINV, MAXV, MAXV, MAXV, MAXV));
        send_request(make_req(MAXV, MAXV, MINV, MINV, MINV, MAXV));
        send_request(make_req(0, 0, ONE, 0, -ONE, 5 * ONE));
        send_request(make_req(0, 0, ONE, 0, 2 * ONE, -3));
        send_request(make_req(0, 0, 0, 3 * ONE, 7, ONE));
        send_request(make_req(-5, -7, -5, -7, MAXV, MINV));
        send_request(make_req(0, 0, -3, -7, -1, -1));
        send_request(make_req(1, 0, 0, 1, 0, 0));
        send_request(make_req(0, 0, 3, 0, 1, 0));
        send_request(make_req(MINV, 0, MAXV, 0, 0, MAXV));
        send_request(make_req(0, MINV, 0, MAXV, MINV, -1));
        send_request(make_req(-1, -1, 1, 1, 1, -1));
        send_request(make_req(ONE, ONE, 2 * ONE, ONE, 2 * ONE + 1, MAXV));
        send_request(make_req(ONE, ONE, 2 * ONE, ONE, ONE - 1, MINV));
        send_request(make_req(MAXV, MINV, MINV, MAXV, 0, 0));
    endtask

    task automatic run_random(input int count);
        repeat (count)
            send_request(random_request());
    endtask

    task automatic test_random_light_gaps();
        idle_pct = 28;
        run_random(700);
    endtask

    task automatic test_random_heavy_gaps();
        idle_pct = 68;
        run_random(700);
    endtask

    task automatic test_random_back_to_back();
        idle_pct = 0;
        run_random(600);
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_random_light_gaps();
        test_random_heavy_gaps();
        test_random_back_to_back();

        start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (TF + 10) @(posedge clk);

        $display("Checked %0d requests with sender gaps of 28, 68 and 0 in a hundred cycles.",
                 requests_taken);
        $display("Regions seen: %0d start, %0d interior, %0d end, %0d degenerate.",
                 region_seen[REGION_START], region_seen[REGION_INTERIOR],
                 region_seen[REGION_END], region_seen[REGION_DEGENERATE]);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
sv/cps_pkg.sv
sv/cps_front.sv
sv/cps_div_step.sv
sv/cps_divider.sv
sv/cps_interp.sv
sv/closest_point_on_segment.sv
dv/closest_point_on_segment_tb.sv
